// ----- rtl/core/pafilt_pkg.sv -----
// Shared types and constants for the proxy address filter table.
// Used by pafilt_cell and proxy_address_filter_table; depends on nothing else.
`timescale 1ns / 1ps

package pafilt_pkg;

  localparam int ADDR_W            = 16;
  localparam int COUNT_W           = 5;
  localparam int CODE_W            = 8;
  localparam int TABLE_ENTRIES_DEF = 16;

  localparam logic [ADDR_W-1:0]  ADDR_EMPTY     = 16'h0000;
  localparam logic [ADDR_W-1:0]  ADDR_ALL_NODES = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 5'd31;
  localparam logic [CODE_W-1:0]  CODE_ACCEPT    = 8'h00;
  localparam logic [CODE_W-1:0]  CODE_REJECT    = 8'h01;

  typedef enum logic [2:0] {
    KIND_SET_MODE = 3'd0,
    KIND_ADD      = 3'd1,
    KIND_REMOVE   = 3'd2,
    KIND_MATCH    = 3'd3,
    KIND_OBSERVE  = 3'd4,
    KIND_CLEAR    = 3'd5,
    KIND_NOTIFY   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_ACCEPT = 2'd1,
    MODE_REJECT = 2'd2
  } mode_t;

  // Operation carried by a token as it walks down the row of cells.
  typedef enum logic [1:0] {
    PASS_FIND   = 2'd0,
    PASS_INSERT = 2'd1,
    PASS_DELETE = 2'd2
  } pass_op_t;

  // What the controller finishes once a pass returns.
  typedef enum logic [1:0] {
    ACT_ADD       = 2'd0,
    ACT_REMOVE    = 2'd1,
    ACT_MATCH_ACC = 2'd2,
    ACT_MATCH_REJ = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FIND  = 2'd1,
    ST_WRITE = 2'd2
  } state_t;

  // The token handed from cell to cell. The flag means "address found" on a
  // find pass and "write done" on an insert or delete pass.
  typedef struct packed {
    logic               valid;
    pass_op_t           op;
    logic [ADDR_W-1:0]  addr;
    logic               flag;
    logic [COUNT_W-1:0] count;
  } token_t;

endpackage

// ----- rtl/core/pafilt_cell.sv -----
// One table slot of the proxy address filter: holds one address and passes
// the token on to its neighbor in the next cycle. Depends on pafilt_pkg.
`timescale 1ns / 1ps

module pafilt_cell import pafilt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   clear,
  input  token_t tok_in,
  output token_t tok_out
);

  logic [ADDR_W-1:0] entry_r;
  logic [ADDR_W-1:0] entry_nxt;
  token_t            tok_r;
  token_t            tok_nxt;
  logic              hit;
  logic              empty;

  assign hit   = (entry_r == tok_in.addr);
  assign empty = (entry_r == ADDR_EMPTY);

  always_comb begin
    entry_nxt = entry_r;
    tok_nxt   = tok_in;
    if (tok_in.valid) begin
      case (tok_in.op)
        PASS_FIND: begin
          tok_nxt.flag = tok_in.flag | hit;
        end
        PASS_INSERT: begin
          if (!tok_in.flag && empty) begin
            entry_nxt    = tok_in.addr;
            tok_nxt.flag = 1'b1;
          end
        end
        PASS_DELETE: begin
          if (!tok_in.flag && hit) begin
            entry_nxt    = ADDR_EMPTY;
            tok_nxt.flag = 1'b1;
          end
        end
        default: begin
          entry_nxt = entry_r;
        end
      endcase
    end
    // Running count of occupied slots, taken after this slot's update.
    if ((entry_nxt != ADDR_EMPTY) && (tok_in.count != COUNT_MAX)) begin
      tok_nxt.count = tok_in.count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      entry_r <= ADDR_EMPTY;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- rtl/core/proxy_address_filter_table.sv -----
// Top level of the proxy address filter table: control sequencer plus a row
// of pafilt_cell slots. Depends on pafilt_pkg and pafilt_cell.
`timescale 1ns / 1ps

// A command beat is taken on a rising edge with start high and busy low, and
// its single result beat appears on the out_ ports for exactly one cycle,
// marked by out_valid; the receiver has no way to stall it, so it must sample
// every strobe. How long a command runs depends on its kind, because the table
// is a row of TABLE_ENTRIES cells and a lookup or a write travels along that
// row one cell per cycle. Set mode, clear on connect, notify enable, unused
// kinds, and any add, remove or match that needs no table access (address
// zero, all-nodes in accept mode, none mode) answer in the cycle after the
// command is taken. Remove and every table-backed match walk the row once.
// Add (and observe source in accept mode) first walks the row to look for a
// duplicate and, if none is found, walks it again to claim the lowest empty
// slot; it walks only once when the address is already present. busy is high
// during those walks. The table, mode and count clear on reset, and a clear
// takes effect on all slots at once. entry_count saturates at 31 for tables
// larger than that.

module proxy_address_filter_table import pafilt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [CODE_W-1:0]  in_mode_code,
  output logic               out_valid,
  output logic               out_error,
  output logic               out_matched,
  output logic               out_table_full_drop,
  output logic [1:0]         out_list_mode,
  output logic [COUNT_W-1:0] out_entry_count
);

  // Token chain: tok_w[0] is what the sequencer launches, tok_w[k+1] is what
  // cell k hands to its neighbor, and the last one returns to the sequencer.
  token_t tok_w [TABLE_ENTRIES+1];
  logic   clear_all;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      pafilt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear_all),
        .tok_in  (tok_w[gi]),
        .tok_out (tok_w[gi+1])
      );
    end
  endgenerate

  token_t ret_tok;
  assign ret_tok = tok_w[TABLE_ENTRIES];

  // Control state.
  state_t             state_r,      state_nxt;
  mode_t              mode_r,       mode_nxt;
  logic [COUNT_W-1:0] used_count_r, used_count_nxt;
  act_t               act_r,        act_nxt;
  logic [ADDR_W-1:0]  addr_r,       addr_nxt;

  // Result beat registers.
  logic               out_valid_r,  out_valid_nxt;
  logic               out_error_r,  out_error_nxt;
  logic               out_matched_r, out_matched_nxt;
  logic               out_drop_r,   out_drop_nxt;
  logic [1:0]         out_mode_r;
  logic [COUNT_W-1:0] out_count_r,  out_count_nxt;

  token_t launch;
  logic   want_add;
  logic   want_remove;
  kind_t  kind;

  assign kind = kind_t'(in_kind);

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    used_count_nxt  = used_count_r;
    act_nxt         = act_r;
    addr_nxt        = addr_r;
    out_valid_nxt   = 1'b0;
    out_error_nxt   = 1'b0;
    out_matched_nxt = 1'b0;
    out_drop_nxt    = 1'b0;
    out_count_nxt   = used_count_r;
    clear_all       = 1'b0;
    want_add        = 1'b0;
    want_remove     = 1'b0;
    launch          = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          addr_nxt      = in_address;
          out_valid_nxt = 1'b1;
          case (kind)
            KIND_SET_MODE: begin
              if (in_mode_code == CODE_ACCEPT) begin
                clear_all      = 1'b1;
                mode_nxt       = MODE_ACCEPT;
                used_count_nxt = '0;
                out_count_nxt  = '0;
              end else if (in_mode_code == CODE_REJECT) begin
                clear_all      = 1'b1;
                mode_nxt       = MODE_REJECT;
                used_count_nxt = '0;
                out_count_nxt  = '0;
              end else begin
                out_error_nxt = 1'b1;
              end
            end
            KIND_ADD: begin
              want_add = 1'b1;
            end
            KIND_REMOVE: begin
              want_remove = 1'b1;
            end
            KIND_MATCH: begin
              if (mode_r == MODE_REJECT) begin
                out_valid_nxt = 1'b0;
                launch.valid  = 1'b1;
                launch.op     = PASS_FIND;
                launch.addr   = in_address;
                act_nxt       = ACT_MATCH_REJ;
                state_nxt     = ST_FIND;
              end else if (in_address == ADDR_ALL_NODES) begin
                out_matched_nxt = 1'b1;
              end else if (mode_r == MODE_ACCEPT) begin
                out_valid_nxt = 1'b0;
                launch.valid  = 1'b1;
                launch.op     = PASS_FIND;
                launch.addr   = in_address;
                act_nxt       = ACT_MATCH_ACC;
                state_nxt     = ST_FIND;
              end else begin
                out_matched_nxt = 1'b0;
              end
            end
            KIND_OBSERVE: begin
              if (mode_r == MODE_ACCEPT) begin
                want_add = 1'b1;
              end else if (mode_r == MODE_REJECT) begin
                want_remove = 1'b1;
              end
            end
            KIND_CLEAR: begin
              clear_all      = 1'b1;
              mode_nxt       = MODE_NONE;
              used_count_nxt = '0;
              out_count_nxt  = '0;
            end
            KIND_NOTIFY: begin
              if (mode_r == MODE_NONE) begin
                mode_nxt = MODE_ACCEPT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase

          // Address zero never touches the table on add or remove.
          if (want_add && (in_address != ADDR_EMPTY)) begin
            out_valid_nxt = 1'b0;
            launch.valid  = 1'b1;
            launch.op     = PASS_FIND;
            launch.addr   = in_address;
            act_nxt       = ACT_ADD;
            state_nxt     = ST_FIND;
          end
          if (want_remove && (in_address != ADDR_EMPTY)) begin
            out_valid_nxt = 1'b0;
            launch.valid  = 1'b1;
            launch.op     = PASS_DELETE;
            launch.addr   = in_address;
            act_nxt       = ACT_REMOVE;
            state_nxt     = ST_WRITE;
          end
        end
      end

      ST_FIND: begin
        if (ret_tok.valid) begin
          out_count_nxt = ret_tok.count;
          case (act_r)
            ACT_ADD: begin
              if (ret_tok.flag) begin
                // Already present: nothing to write.
                out_valid_nxt = 1'b1;
                state_nxt     = ST_IDLE;
              end else begin
                launch.valid = 1'b1;
                launch.op    = PASS_INSERT;
                launch.addr  = addr_r;
                state_nxt    = ST_WRITE;
              end
            end
            ACT_MATCH_ACC: begin
              out_valid_nxt   = 1'b1;
              out_matched_nxt = ret_tok.flag;
              state_nxt       = ST_IDLE;
            end
            ACT_MATCH_REJ: begin
              out_valid_nxt   = 1'b1;
              out_matched_nxt = !ret_tok.flag;
              state_nxt       = ST_IDLE;
            end
            default: begin
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          endcase
        end
      end

      ST_WRITE: begin
        if (ret_tok.valid) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = ret_tok.count;
          used_count_nxt = ret_tok.count;
          // An insert that reached the end without claiming a slot was dropped.
          out_drop_nxt   = (act_r == ACT_ADD) && !ret_tok.flag;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign tok_w[0] = launch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_NONE;
      used_count_r <= '0;
      act_r        <= ACT_ADD;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      used_count_r <= used_count_nxt;
      act_r        <= act_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r        <= addr_nxt;
    out_error_r   <= out_error_nxt;
    out_matched_r <= out_matched_nxt;
    out_drop_r    <= out_drop_nxt;
    out_mode_r    <= mode_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_error           = out_error_r;
  assign out_matched         = out_matched_r;
  assign out_table_full_drop = out_drop_r;
  assign out_list_mode       = out_mode_r;
  assign out_entry_count     = out_count_r;

endmodule
